### src/sbc_pkg.sv
// shared types, constants and helpers for the block distortion / cost unit
// no dependencies; imported by every module of the unit
`default_nettype none
package sbc_pkg;

    localparam int MAX_SIZE  = 32;
    localparam int STORE_AW  = 10;     // log2(MAX_SIZE*MAX_SIZE)
    localparam int DIFF_W    = 19;
    localparam int SMP_W     = 8;
    localparam int DIST_W    = 29;
    localparam int COST_W    = 44;
    localparam int ACC_W     = 18;
    localparam int TOT_W     = 11;
    localparam int DIM_W     = 6;
    localparam int QP_W      = 6;
    localparam int LOG_W     = 3;
    localparam int POS_W     = 5;      // log2(MAX_SIZE)
    localparam int PAIR_W    = 4;
    localparam int MANT_W    = 17;
    localparam int PROD_W    = DIST_W + MANT_W;
    localparam int SH_W      = 5;
    localparam int CFG_IDX_W = 2;
    localparam logic [QP_W-1:0] QP_MAX = 6'd51;
    localparam logic [SH_W-1:0] LAMBDA_FRAC = 5'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_SATD = 2'd0,
        CFG_QP       = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_HEIGHT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_XFORM = 2'd1,
        ST_SUM   = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        PH_RD_A = 2'd0,
        PH_RD_B = 2'd1,
        PH_WR_A = 2'd2,
        PH_WR_B = 2'd3
    } t_phase;

    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] dist_val;
        logic [QP_W-1:0]   qp;
    } t_cost_req;

    // lambda mantissas, 0.85 * 2^(r/3) in Q16
    function automatic logic [MANT_W-1:0] lambda_mant(input logic [1:0] r);
        logic [MANT_W-1:0] m;
        case (r)
            2'd0:    m = 17'd55706;
            2'd1:    m = 17'd70185;
            default: m = 17'd88427;
        endcase
        return m;
    endfunction

    // qp / 3 for qp <= 51 via reciprocal multiply
    function automatic logic [SH_W-1:0] qp_div3(input logic [QP_W-1:0] qp);
        logic [12:0] p;
        p = 13'(qp) * 13'd43;
        return p[11:7];
    endfunction

endpackage
`default_nettype wire

### src/sbc_diff_ram.sv
// difference store: 1024 x 19 bit, one write port, one registered read port
// uses sbc_pkg
`default_nettype none
module sbc_diff_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [sbc_pkg::STORE_AW-1:0]  i_wr_addr,
    input  wire logic [sbc_pkg::DIFF_W-1:0]    i_wr_data,
    input  wire logic [sbc_pkg::STORE_AW-1:0]  i_rd_addr,
    output logic      [sbc_pkg::DIFF_W-1:0]    o_rd_data
);
    import sbc_pkg::*;

    logic [DIFF_W-1:0] r_mem [0:(1<<STORE_AW)-1];
    logic [DIFF_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

### src/sbc_engine.sv
// sample loader, in-place hadamard sequencer and coefficient summer
// uses sbc_pkg and sbc_diff_ram
`default_nettype none
module sbc_engine (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [sbc_pkg::SMP_W-1:0]      i_orig_sample,
    input  wire logic [sbc_pkg::SMP_W-1:0]      i_pred_sample,
    input  wire logic                           i_cfg_we,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sbc_pkg::DIM_W-1:0]      i_cfg_data,
    output sbc_pkg::t_cost_req                  o_req
);
    import sbc_pkg::*;

    logic              r_use_satd;
    logic [QP_W-1:0]   r_qp;
    logic [DIM_W-1:0]  r_bw, r_bh;
    t_state            r_state, n_state;
    logic [STORE_AW-1:0] r_cnt, n_cnt;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [LOG_W-1:0]  r_ln, n_ln;
    logic [LOG_W-1:0]  r_shift, n_shift;
    logic              r_col, n_col;
    logic [POS_W-1:0]  r_line, n_line;
    logic [LOG_W-1:0]  r_stage, n_stage;
    logic [PAIR_W-1:0] r_pair, n_pair;
    t_phase            r_phase, n_phase;
    logic [DIFF_W-1:0] r_a, n_a, r_b, n_b;
    logic [TOT_W-1:0]  r_k, n_k, r_tot, n_tot;
    logic              r_rdv, n_rdv;
    logic [DIST_W-1:0] r_sum, n_sum;
    t_cost_req         r_req, n_req;

    logic [DIM_W-1:0]  w, h;
    logic [TOT_W-1:0]  total;
    logic [LOG_W-1:0]  wln;
    logic              accept, last, square;
    logic [SMP_W:0]    d;
    logic [SMP_W-1:0]  absd;
    logic [ACC_W-1:0]  acc_sum;
    logic [STORE_AW-1:0] cnt_inc;
    logic [POS_W-1:0]  mask, j, n_last;
    logic [PAIR_W-1:0] half_last;
    logic [STORE_AW-1:0] ia, ib, step;
    logic              pass_done;
    logic [DIFF_W-1:0] rd_data, abs_rd;
    logic              wr_en;
    logic [STORE_AW-1:0] wr_addr, rd_addr;
    logic [DIFF_W-1:0] wr_data;

    sbc_diff_ram u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        w = (r_bw == '0) ? DIM_W'(1) : (r_bw > DIM_W'(MAX_SIZE)) ? DIM_W'(MAX_SIZE) : r_bw;
        h = (r_bh == '0) ? DIM_W'(1) : (r_bh > DIM_W'(MAX_SIZE)) ? DIM_W'(MAX_SIZE) : r_bh;
        total = TOT_W'(w) * TOT_W'(h);
        case (w)
            6'd4:    wln = 3'd2;
            6'd8:    wln = 3'd3;
            6'd16:   wln = 3'd4;
            6'd32:   wln = 3'd5;
            default: wln = 3'd0;
        endcase
        square  = r_use_satd && (w == h) && (wln != '0);
        accept  = start && (r_state == ST_IDLE);
        d       = {1'b0, i_orig_sample} - {1'b0, i_pred_sample};
        absd    = d[SMP_W] ? SMP_W'(-d) : d[SMP_W-1:0];
        acc_sum = r_acc + ACC_W'(absd);
        cnt_inc = r_cnt + 1'b1;
        last    = (cnt_inc == '0) || ({1'b0, cnt_inc} >= total);

        // butterfly partner positions: insert a zero bit at the stage position
        mask      = (POS_W'(1) << r_stage) - 1'b1;
        j         = POS_W'(r_pair) + (POS_W'(r_pair) & ~mask);
        step      = STORE_AW'(1) << r_stage;
        ia        = r_col ? ((STORE_AW'(j) << r_ln) | STORE_AW'(r_line))
                          : ((STORE_AW'(r_line) << r_ln) | STORE_AW'(j));
        ib        = ia + (r_col ? (step << r_ln) : step);
        n_last    = POS_W'((6'd1 << r_ln) - 1'b1);
        half_last = PAIR_W'((5'd1 << (r_ln - 1'b1)) - 1'b1);
        pass_done = (r_pair == half_last) && (r_stage == r_ln - 1'b1) && (r_line == n_last);
        abs_rd    = rd_data[DIFF_W-1] ? DIFF_W'(-rd_data) : rd_data;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && last && square) n_state = ST_XFORM;
            end
            ST_XFORM: begin
                if (r_phase == PH_WR_B && pass_done && r_col) n_state = ST_SUM;
            end
            ST_SUM: begin
                if (r_k == r_tot && !r_rdv) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;  n_acc = r_acc;  n_ln = r_ln;  n_shift = r_shift;
        n_col = r_col;  n_line = r_line; n_stage = r_stage; n_pair = r_pair;
        n_phase = r_phase; n_a = r_a; n_b = r_b; n_k = r_k; n_tot = r_tot;
        n_rdv = 1'b0;   n_sum = r_sum;
        n_req = '{vld: 1'b0, dist_val: r_req.dist_val, qp: r_req.qp};
        wr_en = 1'b0;   wr_addr = r_cnt; wr_data = DIFF_W'($signed(d));
        rd_addr = ia;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    wr_en = 1'b1;
                    n_cnt = cnt_inc;
                    n_acc = acc_sum;
                    if (last) begin
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_ln    = wln;
                        n_shift = (wln == '0) ? '0 : wln - 1'b1;
                        n_tot   = total;
                        n_col = 1'b0; n_line = '0; n_stage = '0; n_pair = '0;
                        n_phase = PH_RD_A;
                        if (!square) begin
                            n_req.vld      = 1'b1;
                            n_req.qp       = r_qp;
                            n_req.dist_val = r_use_satd
                                ? DIST_W'(acc_sum >> ((wln == '0) ? 3'd0 : wln - 1'b1))
                                : DIST_W'(acc_sum);
                        end
                    end
                end
            end
            ST_XFORM: begin
                unique case (r_phase)
                    PH_RD_A: begin
                        rd_addr = ia;
                        n_phase = PH_RD_B;
                    end
                    PH_RD_B: begin
                        rd_addr = ib;
                        n_a     = rd_data;
                        n_phase = PH_WR_A;
                    end
                    PH_WR_A: begin
                        wr_en   = 1'b1;
                        wr_addr = ia;
                        wr_data = r_a + rd_data;
                        n_b     = rd_data;
                        n_phase = PH_WR_B;
                    end
                    PH_WR_B: begin
                        wr_en   = 1'b1;
                        wr_addr = ib;
                        wr_data = r_a - r_b;
                        n_phase = PH_RD_A;
                        if (r_pair != half_last) begin
                            n_pair = r_pair + 1'b1;
                        end else begin
                            n_pair = '0;
                            if (r_stage != r_ln - 1'b1) begin
                                n_stage = r_stage + 1'b1;
                            end else begin
                                n_stage = '0;
                                if (r_line != n_last) begin
                                    n_line = r_line + 1'b1;
                                end else begin
                                    n_line = '0;
                                    n_col  = 1'b1;
                                    n_k    = '0;
                                    n_sum  = '0;
                                end
                            end
                        end
                    end
                    default: n_phase = PH_RD_A;
                endcase
            end
            ST_SUM: begin
                rd_addr = r_k[STORE_AW-1:0];
                if (r_k != r_tot) begin
                    n_k   = r_k + 1'b1;
                    n_rdv = 1'b1;
                end
                if (r_rdv) n_sum = r_sum + DIST_W'(abs_rd);
                if (r_k == r_tot && !r_rdv) begin
                    n_req.vld      = 1'b1;
                    n_req.qp       = r_qp;
                    n_req.dist_val = r_sum >> r_shift;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_satd <= 1'b1;
            r_qp       <= 6'd32;
            r_bw       <= 6'd8;
            r_bh       <= 6'd8;
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_acc      <= '0;
            r_rdv      <= 1'b0;
            r_req.vld  <= 1'b0;
            r_phase    <= PH_RD_A;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_USE_SATD: r_use_satd <= i_cfg_data[0];
                    CFG_QP:       r_qp       <= i_cfg_data;
                    CFG_WIDTH:    r_bw       <= i_cfg_data;
                    CFG_HEIGHT:   r_bh       <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_rdv     <= n_rdv;
            r_req.vld <= n_req.vld;
            r_phase   <= n_phase;
        end
        r_ln  <= n_ln;   r_shift <= n_shift; r_col <= n_col; r_line <= n_line;
        r_stage <= n_stage; r_pair <= n_pair; r_a <= n_a; r_b <= n_b;
        r_k   <= n_k;    r_tot <= n_tot;     r_sum <= n_sum;
        r_req.dist_val <= n_req.dist_val;
        r_req.qp       <= n_req.qp;
    end

    assign busy  = (r_state != ST_IDLE);
    assign o_req = r_req;
endmodule
`default_nettype wire

### src/sbc_cost.sv
// lambda scaling: distortion times q16 mantissa, shifted by the qp exponent
// uses sbc_pkg; two register stages
`default_nettype none
module sbc_cost (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  sbc_pkg::t_cost_req              i_req,
    output logic                            o_valid,
    output logic [sbc_pkg::DIST_W-1:0]      o_distortion,
    output logic [sbc_pkg::COST_W-1:0]      o_cost
);
    import sbc_pkg::*;

    logic [QP_W-1:0]   qp;
    logic [SH_W-1:0]   q3;
    logic [1:0]        rem;
    logic              r_vld1, r_vld2;
    logic [DIST_W-1:0] r_dist1, r_dist2;
    logic [PROD_W-1:0] r_prod;
    logic [SH_W-1:0]   r_sh;
    logic [COST_W-1:0] r_cost;

    always_comb begin
        qp  = (i_req.qp > QP_MAX) ? QP_MAX : i_req.qp;
        q3  = qp_div3(qp);
        rem = 2'(qp - QP_W'(q3) * 6'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_req.vld;
            r_vld2 <= r_vld1;
        end
        r_dist1 <= i_req.dist_val;
        r_prod  <= PROD_W'(i_req.dist_val) * PROD_W'(lambda_mant(rem));
        r_sh    <= LAMBDA_FRAC - q3;
        r_dist2 <= r_dist1;
        r_cost  <= COST_W'(r_prod >> r_sh);
    end

    assign o_valid      = r_vld2;
    assign o_distortion = r_dist2;
    assign o_cost       = r_cost;
endmodule
`default_nettype wire

### src/satd_sad_block_cost_unit.sv
// top level of the block distortion / rate-distortion cost unit
// uses sbc_pkg, sbc_engine, sbc_cost
//
// channel   direction  handshake            payload
// sample    in         start / busy         i_orig_sample, i_pred_sample
// result    out        o_valid (1 cycle)    o_distortion, o_cost
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// samples load at one per cycle while start is high and busy is low; busy stays low while a block fills.
// a sad block, or a satd block of non-transformable shape, gives its result
// through the engine request register and the cost pipeline, and busy never rises.
// a square n x n satd block (n = 4, 8, 16, 32) runs the hadamard on the one
// ram port pair, each butterfly reading a and b and writing a+b and a-b, in a
// row pass, then a column pass, then a coefficient readout; busy is high throughout.
// reset is synchronous; the ram needs no clearing. results cannot be stalled.
`default_nettype none
module satd_sad_block_cost_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [sbc_pkg::SMP_W-1:0]      i_orig_sample,
    input  wire logic [sbc_pkg::SMP_W-1:0]      i_pred_sample,
    input  wire logic                           i_cfg_we,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sbc_pkg::DIM_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    output logic [sbc_pkg::DIST_W-1:0]          o_distortion,
    output logic [sbc_pkg::COST_W-1:0]          o_cost
);
    import sbc_pkg::*;

    t_cost_req req;

    sbc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_orig_sample(i_orig_sample),
        .i_pred_sample(i_pred_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_req        (req)
    );

    sbc_cost u_cost (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_valid     (o_valid),
        .o_distortion(o_distortion),
        .o_cost      (o_cost)
    );
endmodule
`default_nettype wire

### src/sbc_checker.sv
// port-level checks for the cost unit, bound to the top level
// uses sbc_pkg
`default_nettype none
module sbc_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      o_valid,
    input wire logic [sbc_pkg::DIST_W-1:0] o_distortion,
    input wire logic [sbc_pkg::COST_W-1:0] o_cost
);
    import sbc_pkg::*;

    // no result right after a reset cycle
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // busy only rises from an accepted last sample
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // end of a transform always yields a result
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> ##2 o_valid)
        else $error("no result after transform");

    a_zero_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_distortion == '0) |-> (o_cost == '0))
        else $error("nonzero cost for zero distortion");
endmodule

bind satd_sad_block_cost_unit sbc_checker u_sbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_distortion(o_distortion),
    .o_cost      (o_cost)
);
`default_nettype wire
